>>> rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the station identity tracker
// Hash and fold constants, table sizing, table entry layout, register indexes.
// ----------------------------------------------------------------------------
package sit_pkg;

   // station table
   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // field widths
   localparam int MAC_W     = 48;
   localparam int MAC_BYTES = MAC_W / 8;
   localparam int HASH_W    = 64;
   localparam int HASH_BYTES = HASH_W / 8;
   localparam int STN_W     = 16;
   localparam int SEQ_W     = 32;
   localparam int NODE_W    = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 64;

   // FNV-1a 64 prime is 2^40 + 0x1b3
   localparam int             PRIME_SHIFT = 40;
   localparam logic [8:0]     PRIME_LOW   = 9'h1b3;
   localparam logic [8:0]     FOLD_MULT   = 9'h193;
   localparam logic [15:0]    FOLD_START  = 16'h811c;
   localparam logic [63:0]    BASIS_RESET = 64'hcbf29ce484222325;
   localparam logic [NODE_W-1:0] NODE_RESET = 8'd1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_NUMBER  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SALTED_BASIS = 8'd1;

   typedef enum logic {
      MIX_HASH,
      MIX_FOLD
   } mix_mode_type;

   typedef struct packed {
      mix_mode_type      mode;
      logic [HASH_W-1:0] acc;
      logic [7:0]        data;
   } mix_op_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [SEQ_W-1:0]  next_seq;
      logic [SEQ_W-1:0]  last_seen;
   } entry_type;

endpackage

>>> rtl/sit_channels.sv
// ----------------------------------------------------------------------------
// sit channels: valid/ready channels of the station identity tracker
// Request (MAC), response (hash, ids, sequences) and register write channels.
// ----------------------------------------------------------------------------
interface sit_req_if;
   logic                         valid;
   logic                         ready;
   logic [sit_pkg::MAC_W-1:0]    source_mac;

   modport source (output valid, output source_mac, input ready);
   modport sink   (input valid, input source_mac, output ready);
endinterface

interface sit_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sit_pkg::HASH_W-1:0]   mac_digest;
   logic [sit_pkg::STN_W-1:0]    station_number;
   logic [sit_pkg::STN_W-1:0]    link_number;
   logic [sit_pkg::SEQ_W-1:0]    station_count;
   logic [sit_pkg::SEQ_W-1:0]    global_count;

   modport source (output valid, output mac_digest, output station_number,
                   output link_number, output station_count, output global_count,
                   input ready);
   modport sink   (input valid, input mac_digest, input station_number,
                   input link_number, input station_count, input global_count,
                   output ready);
endinterface

interface sit_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sit_pkg::CSR_IDX_W-1:0]  index;
   logic [sit_pkg::CSR_DAT_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sit_mix_unit.sv
// ----------------------------------------------------------------------------
// sit_mix_unit: shared xor-multiply round
// One FNV-1a 64 round or one 16-bit fold round, on one small multiplier.
// ----------------------------------------------------------------------------
module sit_mix_unit (
   input  sit_pkg::mix_op_type          op,
   output logic [sit_pkg::HASH_W-1:0]   result
);

   logic [sit_pkg::HASH_W-1:0] mixed;
   logic [8:0]                 factor;
   logic [sit_pkg::HASH_W-1:0] product;

   always_comb begin
      mixed   = op.acc ^ {{(sit_pkg::HASH_W-8){1'b0}}, op.data};
      factor  = (op.mode == sit_pkg::MIX_HASH) ? sit_pkg::PRIME_LOW : sit_pkg::FOLD_MULT;
      product = mixed * {{(sit_pkg::HASH_W-9){1'b0}}, factor};
      if (op.mode == sit_pkg::MIX_HASH) begin
         // high part of the prime is a plain shift
         result = product + (mixed << sit_pkg::PRIME_SHIFT);
      end else begin
         result = {{(sit_pkg::HASH_W-sit_pkg::STN_W){1'b0}}, product[sit_pkg::STN_W-1:0]};
      end
   end

endmodule

>>> rtl/station_identity_tracker_top.sv
// ----------------------------------------------------------------------------
// station_identity_tracker_top: salted FNV-1a 64 station table with LRU refill
// Hashes each source MAC, folds a 16-bit station id, looks the hash up in the
// station table and returns hash, ids and per-station and global sequences.
// ----------------------------------------------------------------------------
//
//  channel   dir  transfer when       payload
//  --------  ---  ------------------  ----------------------------------------
//  req_chan  in   valid & ready       source_mac[47:0]
//  rsp_chan  out  valid & ready       mac_digest, station_number, link_number,
//                                     station_count, global_count
//  csr_chan  in   valid & ready       index[7:0], data[63:0] (0 node, 1 basis)
//
//  req_chan.ready stays low from a MAC transfer until the block is idle again:
//  one hash round per MAC byte, then a table scan of one slot read per cycle
//  (one read per slot, compared on the registered read data), then a
//  write-back. The fold rounds, one per hash byte, share the round unit and run
//  under the scan; an early hit waits for them.
//  A finished result sits in the output register, so the next MAC is taken
//  while it waits; the write-back stalls while that register is still full or the fold is unfinished.
//  Reset clears the valid bit of every slot at once: no clearing pass.
//  csr_chan is always ready.
//
module station_identity_tracker_top (
   input  logic       clock,
   input  logic       reset,
   sit_req_if.sink    req_chan,
   sit_rsp_if.source  rsp_chan,
   sit_csr_if.sink    csr_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_WRITE
   } state_type;

   localparam int IDX_W = sit_pkg::IDX_W;
   localparam int CNT_W = sit_pkg::CNT_W;
   localparam int SEQ_W = sit_pkg::SEQ_W;
   localparam int STN_W = sit_pkg::STN_W;
   localparam int HASH_W = sit_pkg::HASH_W;
   localparam int FOLD_CNT_W = $clog2(sit_pkg::HASH_BYTES + 1);
   localparam int HASH_CNT_W = $clog2(sit_pkg::MAC_BYTES);

   // control state
   state_type                   state_ff, state_in;
   logic [sit_pkg::SLOTS-1:0]   used_ff, used_in;
   logic [SEQ_W-1:0]            tick_ff, tick_in;
   logic [SEQ_W-1:0]            frame_ff, frame_in;
   logic [sit_pkg::NODE_W-1:0]  node_ff, node_in;
   logic [HASH_W-1:0]           basis_ff, basis_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [HASH_CNT_W-1:0]       hash_round_ff, hash_round_in;
   logic [FOLD_CNT_W-1:0]       fold_round_ff, fold_round_in;
   logic [CNT_W-1:0]            scan_cnt_ff, scan_cnt_in;
   logic                        cmp_live_ff, cmp_live_in;
   logic                        have_empty_ff, have_empty_in;

   // payload
   logic [sit_pkg::MAC_W-1:0]   mac_ff, mac_in;
   logic [HASH_W-1:0]           hash_ff, hash_in;
   logic [STN_W-1:0]            fold_ff, fold_in;
   logic [IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]            empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]            oldest_idx_ff, oldest_idx_in;
   logic [SEQ_W-1:0]            oldest_seen_ff, oldest_seen_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic [SEQ_W-1:0]            seq_ff, seq_in;
   logic [HASH_W-1:0]           out_hash_ff, out_hash_in;
   logic [STN_W-1:0]            out_station_ff, out_station_in;
   logic [STN_W-1:0]            out_link_ff, out_link_in;
   logic [SEQ_W-1:0]            out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0]            out_global_ff, out_global_in;

   // shared round unit and table memory
   sit_pkg::mix_op_type         mix_op;
   logic [HASH_W-1:0]           mix_result;
   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_rd_addr;
   sit_pkg::entry_type          ram_wr_entry;
   logic [$bits(sit_pkg::entry_type)-1:0] ram_rd_data;
   sit_pkg::entry_type          entry;

   // scan and finish helpers
   logic                        cur_used;
   logic                        cur_hit;
   logic                        cur_last;
   logic                        fold_done;
   logic                        out_free;
   logic [STN_W-1:0]            station;
   logic [STN_W-1:0]            link_raw;

   sit_mix_unit u_mix (
      .op     (mix_op),
      .result (mix_result)
   );

   sit_ram #(
      .WIDTH ($bits(sit_pkg::entry_type)),
      .DEPTH (sit_pkg::SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_entry),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.mac_digest     = out_hash_ff;
   assign rsp_chan.station_number = out_station_ff;
   assign rsp_chan.link_number    = out_link_ff;
   assign rsp_chan.station_count  = out_seq_ff;
   assign rsp_chan.global_count   = out_global_ff;

   // The round unit runs hash rounds in ST_HASH and fold rounds otherwise.
   always_comb begin
      mix_op.mode = (state_ff == ST_HASH) ? sit_pkg::MIX_HASH : sit_pkg::MIX_FOLD;
      if (state_ff == ST_HASH) begin
         mix_op.acc  = hash_ff;
         // first transmitted byte (bits 47:40) is absorbed first
         mix_op.data = mac_ff[(sit_pkg::MAC_BYTES - 1 - int'(hash_round_ff)) * 8 +: 8];
      end else begin
         mix_op.acc  = {{(HASH_W-STN_W){1'b0}}, fold_ff};
         // least significant hash byte first
         mix_op.data = hash_ff[int'(fold_round_ff[FOLD_CNT_W-2:0]) * 8 +: 8];
      end
   end

   always_comb begin
      entry     = sit_pkg::entry_type'(ram_rd_data);
      cur_used  = used_ff[cmp_idx_ff];
      cur_hit   = cmp_live_ff && cur_used && (entry.hash == hash_ff);
      cur_last  = (cmp_idx_ff == IDX_W'(sit_pkg::SLOTS - 1));
      fold_done = (fold_round_ff == FOLD_CNT_W'(sit_pkg::HASH_BYTES));
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      station   = (fold_ff == '0) ? STN_W'(1) : fold_ff;
      link_raw  = {node_ff, {(STN_W-sit_pkg::NODE_W){1'b0}}} ^ station;

      ram_rd_addr             = scan_cnt_ff[IDX_W-1:0];
      ram_wr_en               = 1'b0;
      ram_wr_entry.hash       = hash_ff;
      ram_wr_entry.next_seq   = seq_ff + SEQ_W'(1);
      ram_wr_entry.last_seen  = tick_ff + SEQ_W'(1);

      state_in       = state_ff;
      used_in        = used_ff;
      tick_in        = tick_ff;
      frame_in       = frame_ff;
      node_in        = node_ff;
      basis_in       = basis_ff;
      rsp_valid_in   = rsp_valid_ff;
      hash_round_in  = hash_round_ff;
      fold_round_in  = fold_round_ff;
      scan_cnt_in    = scan_cnt_ff;
      cmp_live_in    = cmp_live_ff;
      have_empty_in  = have_empty_ff;
      mac_in         = mac_ff;
      hash_in        = hash_ff;
      fold_in        = fold_ff;
      cmp_idx_in     = cmp_idx_ff;
      empty_idx_in   = empty_idx_ff;
      oldest_idx_in  = oldest_idx_ff;
      oldest_seen_in = oldest_seen_ff;
      slot_in        = slot_ff;
      seq_in         = seq_ff;
      out_hash_in    = out_hash_ff;
      out_station_in = out_station_ff;
      out_link_in    = out_link_ff;
      out_seq_in     = out_seq_ff;
      out_global_in  = out_global_ff;

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            sit_pkg::CSR_NODE_NUMBER:  node_in  = csr_chan.data[sit_pkg::NODE_W-1:0];
            sit_pkg::CSR_SALTED_BASIS: basis_in = csr_chan.data;
            default: ;
         endcase
      end

      // fold rounds run under the scan and the write-back wait
      if ((state_ff == ST_SCAN || state_ff == ST_WRITE) && !fold_done) begin
         fold_in       = mix_result[STN_W-1:0];
         fold_round_in = fold_round_ff + FOLD_CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mac_in        = req_chan.source_mac;
               hash_in       = basis_ff;
               hash_round_in = '0;
               state_in      = ST_HASH;
            end
         end

         ST_HASH: begin
            hash_in       = mix_result;
            hash_round_in = hash_round_ff + HASH_CNT_W'(1);
            if (hash_round_ff == HASH_CNT_W'(sit_pkg::MAC_BYTES - 1)) begin
               fold_in       = sit_pkg::FOLD_START;
               fold_round_in = '0;
               scan_cnt_in   = '0;
               cmp_live_in   = 1'b0;
               have_empty_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one slot read per cycle, compare the slot read last cycle
            if (scan_cnt_ff < CNT_W'(sit_pkg::SLOTS)) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               cmp_idx_in  = scan_cnt_ff[IDX_W-1:0];
               cmp_live_in = 1'b1;
            end else begin
               cmp_live_in = 1'b0;
            end

            if (cmp_live_ff) begin
               if (!cur_used && !have_empty_ff) begin
                  have_empty_in = 1'b1;
                  empty_idx_in  = cmp_idx_ff;
               end
               // strict compare keeps the first slot on ties
               if (cmp_idx_ff == '0 || entry.last_seen < oldest_seen_ff) begin
                  oldest_idx_in  = cmp_idx_ff;
                  oldest_seen_in = entry.last_seen;
               end

               if (cur_hit) begin
                  slot_in     = cmp_idx_ff;
                  seq_in      = entry.next_seq;
                  cmp_live_in = 1'b0;
                  state_in    = ST_WRITE;
               end else if (cur_last) begin
                  slot_in     = have_empty_in ? empty_idx_in : oldest_idx_in;
                  seq_in      = '0;
                  cmp_live_in = 1'b0;
                  state_in    = ST_WRITE;
               end
            end
         end

         ST_WRITE: begin
            // hold until the fold is done and the output register is free
            if (fold_done && out_free) begin
               ram_wr_en      = 1'b1;
               used_in        = used_ff | (sit_pkg::SLOTS'(1) << slot_ff);
               tick_in        = tick_ff + SEQ_W'(1);
               frame_in       = frame_ff + SEQ_W'(1);
               out_hash_in    = hash_ff;
               out_station_in = station;
               out_link_in    = (link_raw == '0) ? STN_W'(1) : link_raw;
               out_seq_in     = seq_ff;
               out_global_in  = frame_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         tick_ff       <= '0;
         frame_ff      <= '0;
         node_ff       <= sit_pkg::NODE_RESET;
         basis_ff      <= sit_pkg::BASIS_RESET;
         rsp_valid_ff  <= 1'b0;
         hash_round_ff <= '0;
         fold_round_ff <= '0;
         scan_cnt_ff   <= '0;
         cmp_live_ff   <= 1'b0;
         have_empty_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         tick_ff       <= tick_in;
         frame_ff      <= frame_in;
         node_ff       <= node_in;
         basis_ff      <= basis_in;
         rsp_valid_ff  <= rsp_valid_in;
         hash_round_ff <= hash_round_in;
         fold_round_ff <= fold_round_in;
         scan_cnt_ff   <= scan_cnt_in;
         cmp_live_ff   <= cmp_live_in;
         have_empty_ff <= have_empty_in;
      end
      mac_ff         <= mac_in;
      hash_ff        <= hash_in;
      fold_ff        <= fold_in;
      cmp_idx_ff     <= cmp_idx_in;
      empty_idx_ff   <= empty_idx_in;
      oldest_idx_ff  <= oldest_idx_in;
      oldest_seen_ff <= oldest_seen_in;
      slot_ff        <= slot_in;
      seq_ff         <= seq_in;
      out_hash_ff    <= out_hash_in;
      out_station_ff <= out_station_in;
      out_link_ff    <= out_link_in;
      out_seq_ff     <= out_seq_in;
      out_global_ff  <= out_global_in;
   end

endmodule

>>> test/sit_tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sit_tb_checker: station table predictor and result scoreboard
// Watches request, result and register write transfers, keeps its own copy
// of the station table and registers, and compares each result in order.
// ----------------------------------------------------------------------------
package sit_tb_pkg;

   localparam logic [63:0] FNV_PRIME     = 64'd1099511628211;
   localparam logic [63:0] DEFAULT_BASIS = 64'hcbf29ce484222325;
   localparam logic [7:0]  DEFAULT_NODE  = 8'd1;
   localparam logic [15:0] FOLD_SEED     = 16'h811c;
   localparam logic [15:0] FOLD_PRIME    = 16'h0193;

   // salted FNV-1a 64 over the MAC, first transmitted byte first
   function automatic logic [63:0] salted_hash(input logic [63:0] basis,
                                               input logic [47:0] mac);
      logic [63:0] h;
      h = basis;
      for (int k = 0; k < 6; k++) begin
         h = h ^ {56'd0, mac[47 - 8 * k -: 8]};
         h = h * FNV_PRIME;
      end
      return h;
   endfunction

   // 16-bit fold of the hash, least significant byte first
   function automatic logic [15:0] raw_fold(input logic [63:0] h);
      logic [15:0] v;
      v = FOLD_SEED;
      for (int k = 0; k < 8; k++) begin
         v = v ^ {8'd0, h[8 * k +: 8]};
         v = v * FOLD_PRIME;
      end
      return v;
   endfunction

   function automatic logic [15:0] station_of(input logic [63:0] h);
      logic [15:0] v;
      v = raw_fold(h);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

endpackage

module sit_tb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [sit_pkg::MAC_W-1:0]       req_mac,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [sit_pkg::HASH_W-1:0]      rsp_hash,
   input  logic [sit_pkg::STN_W-1:0]       rsp_station,
   input  logic [sit_pkg::STN_W-1:0]       rsp_link,
   input  logic [sit_pkg::SEQ_W-1:0]       rsp_station_count,
   input  logic [sit_pkg::SEQ_W-1:0]       rsp_global_count,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sit_pkg::CSR_DAT_W-1:0]   csr_data,
   output int                              mismatch_count,
   output int                              results_seen
);
   import sit_pkg::*;
   import sit_tb_pkg::*;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [STN_W-1:0]  station;
      logic [STN_W-1:0]  link;
      logic [SEQ_W-1:0]  station_count;
      logic [SEQ_W-1:0]  global_count;
   } sighting_type;

   // predicted registers and station table
   logic [NODE_W-1:0] node_id;
   logic [HASH_W-1:0] basis;
   logic              seen_valid    [SLOTS];
   logic [HASH_W-1:0] seen_hash     [SLOTS];
   logic [STN_W-1:0]  seen_station  [SLOTS];
   logic [SEQ_W-1:0]  seen_next_seq [SLOTS];
   logic [SEQ_W-1:0]  seen_tick     [SLOTS];
   logic [SEQ_W-1:0]  tick_count;
   logic [SEQ_W-1:0]  frame_count;

   sighting_type expected_sightings[$];

   function automatic sighting_type predict_sighting(input logic [MAC_W-1:0] mac);
      sighting_type s;
      logic [63:0]  h;
      int           i;
      int           pick;
      int           free_slot;
      int           oldest;
      bit           found;
      bit           have_free;
      h         = salted_hash(basis, mac);
      found     = 1'b0;
      have_free = 1'b0;
      pick      = 0;
      free_slot = 0;
      oldest    = 0;
      for (i = 0; i < SLOTS; i++) begin
         if (!found) begin
            if (seen_valid[i] && seen_hash[i] == h) begin
               found = 1'b1;
               pick  = i;
            end else begin
               if (!seen_valid[i] && !have_free) begin
                  have_free = 1'b1;
                  free_slot = i;
               end
               if (seen_tick[i] < seen_tick[oldest]) oldest = i;
            end
         end
      end
      if (!found) begin
         pick                = have_free ? free_slot : oldest;
         seen_valid[pick]    = 1'b1;
         seen_hash[pick]     = h;
         seen_station[pick]  = station_of(h);
         seen_next_seq[pick] = '0;
      end
      tick_count      = tick_count + 1;
      seen_tick[pick] = tick_count;
      s.hash          = h;
      s.station       = seen_station[pick];
      s.link          = {node_id, 8'd0} ^ seen_station[pick];
      if (s.link == 16'd0) s.link = 16'd1;
      s.station_count = seen_next_seq[pick];
      s.global_count  = frame_count;
      seen_next_seq[pick] = seen_next_seq[pick] + 1;
      frame_count         = frame_count + 1;
      return s;
   endfunction

   always @(posedge clock) begin
      sighting_type want;
      sighting_type got;
      if (reset) begin
         node_id     = DEFAULT_NODE;
         basis       = DEFAULT_BASIS;
         tick_count  = '0;
         frame_count = '0;
         for (int i = 0; i < SLOTS; i++) begin
            seen_valid[i]    = 1'b0;
            seen_hash[i]     = '0;
            seen_station[i]  = '0;
            seen_next_seq[i] = '0;
            seen_tick[i]     = '0;
         end
         expected_sightings.delete();
         mismatch_count <= 0;
         results_seen   <= 0;
      end else begin
         // results first: a result never belongs to a request of the same edge
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_hash, rsp_station, rsp_link, rsp_station_count,
                    rsp_global_count};
            results_seen <= results_seen + 1;
            if (expected_sightings.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result hash %h station %h link %h",
                           $realtime, got.hash, got.station, got.link);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_sightings.pop_front();
               if (got.hash != want.hash || got.station != want.station ||
                   got.link != want.link ||
                   got.station_count != want.station_count ||
                   got.global_count != want.global_count) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected hash %h station %h link %h seq %0d global %0d",
                              want.hash, want.station, want.link,
                              want.station_count, want.global_count);
                     $display("   actual   hash %h station %h link %h seq %0d global %0d",
                              got.hash, got.station, got.link,
                              got.station_count, got.global_count);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NODE_NUMBER)
               node_id = csr_data[NODE_W-1:0];
            else if (csr_index == CSR_SALTED_BASIS)
               basis = csr_data;
         end
         if (req_valid && req_ready)
            expected_sightings.push_back(predict_sighting(req_mac));
      end
   end

endmodule

>>> test/station_identity_tracker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_identity_tracker_top_tb: stimulus and verdict for the station tracker
// Drives MAC requests and register writes under varied pacing; a checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module station_identity_tracker_top_tb;
   import sit_pkg::*;
   import sit_tb_pkg::*;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int POOL_MAX        = 32;
   localparam int SEARCH_LIMIT    = 1 << 22;
   // worst quiet stretch: the block's own work plus a long receiver stall
   localparam int WATCHDOG_LIMIT  = 5000;
   // output register plus a full scan, with margin, to catch stray results
   localparam int DRAIN_CYCLES    = 64;

   logic clock = 1'b0;
   logic reset;

   sit_req_if req_bus ();
   sit_rsp_if rsp_bus ();
   sit_csr_if csr_bus ();

   int mismatch_count;
   int results_seen;
   int items_sent = 0;

   // pacing, in percent of cycles spent idle or stalled
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // per-phase MAC population, small enough to produce hits and evictions
   logic [MAC_W-1:0] mac_pool [POOL_MAX];
   int               pool_size = 1;

   station_identity_tracker_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sit_tb_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_mac           (req_bus.source_mac),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_hash          (rsp_bus.mac_digest),
      .rsp_station       (rsp_bus.station_number),
      .rsp_link          (rsp_bus.link_number),
      .rsp_station_count (rsp_bus.station_count),
      .rsp_global_count  (rsp_bus.global_count),
      .csr_valid         (csr_bus.valid),
      .csr_ready         (csr_bus.ready),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .mismatch_count    (mismatch_count),
      .results_seen      (results_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: re-decide ready at every edge; with no stall pct hold it high.
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (recv_idle_pct == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: count edges with no transfer on any channel.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
      end
      $display("watchdog expired at %0t", $realtime);
      $display("FAIL station_identity_tracker_top");
      $finish;
   end

   // Present one MAC and hold it until the transfer. Valid stays high after
   // the transfer so back-to-back requests never drop it; a gap lowers it in
   // the step of the previous transfer and raises it in a later step.
   task automatic send_mac(input logic [MAC_W-1:0] mac);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid      <= 1'b1;
      req_bus.source_mac <= mac;
      do @(posedge clock); while (!req_bus.ready);
      items_sent = items_sent + 1;
   endtask

   // Drop request valid right after the last transfer of a burst.
   task automatic hold_requests();
      req_bus.valid <= 1'b0;
   endtask

   // Same scheme as send_mac: valid stays up across a run of writes.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic hold_writes();
      csr_bus.valid <= 1'b0;
   endtask

   // Block until every request has its result; the result count is registered
   // and lags the transfer, which only makes the wait longer.
   task automatic wait_for_results();
      while (results_seen < items_sent) @(posedge clock);
   endtask

   // Pacing modes: free running, sender idle, receiver stalling, both.
   task automatic set_pacing(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         1: begin
            send_idle_pct = 62;
            recv_idle_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_idle_pct = 62;
         end
         default: begin
            send_idle_pct = 32;
            recv_idle_pct = 32;
         end
      endcase
   endtask

   // Mostly repeat stations of the pool, then noise, then extreme values.
   function automatic logic [MAC_W-1:0] next_random_mac();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return mac_pool[$urandom_range(pool_size - 1)];
      if (pick < 92) return MAC_W'({$urandom, $urandom});
      case ($urandom_range(2))
         0:       return '0;
         1:       return '1;
         default: return 48'd1 << $urandom_range(MAC_W - 1);
      endcase
   endfunction

   initial begin : stimulus
      logic [MAC_W-1:0]     mac;
      logic [MAC_W-1:0]     fold_zero_mac;
      logic [STN_W-1:0]     stn;
      logic [NODE_W-1:0]    node;
      logic [CSR_DAT_W-1:0] basis;
      int                   tries;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.source_mac <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed part, reset register values ----------------
      set_pacing(0);

      // extremes of the MAC, then a hit on the first slot
      send_mac('0);
      send_mac('1);
      send_mac('0);
      send_mac(48'haaaa_aaaa_aaaa);
      send_mac(48'h5555_5555_5555);

      // walking ones fill the rest of the table
      for (int k = 0; k < 12; k++) send_mac(48'd1 << (4 * k + 1));

      // table full: a new station replaces the least recently seen one
      // (the all-ones MAC); bringing that back evicts the next oldest
      send_mac(48'h8000_0000_0000);
      send_mac('1);
      send_mac('0);

      // station id whose fold comes out zero and is forced to one
      tries = 0;
      do begin
         fold_zero_mac = MAC_W'({$urandom, $urandom});
         tries = tries + 1;
      end while (raw_fold(salted_hash(DEFAULT_BASIS, fold_zero_mac)) != 16'd0 &&
                 tries < SEARCH_LIMIT);
      send_mac(fold_zero_mac);
      send_mac(fold_zero_mac);
      hold_requests();

      // link id that comes out zero: pick a station with a zero low byte and
      // set the node number to its high byte
      tries = 0;
      do begin
         mac   = MAC_W'({$urandom, $urandom});
         stn   = station_of(salted_hash(DEFAULT_BASIS, mac));
         tries = tries + 1;
      end while (stn[7:0] != 8'd0 && tries < SEARCH_LIMIT);
      wait_for_results();
      write_reg(CSR_NODE_NUMBER, {56'd0, stn[15:8]});
      // writes to unmapped indexes must leave both registers alone
      write_reg(CSR_IDX_W'(CSR_SALTED_BASIS + 1), {$urandom, $urandom});
      write_reg('1, {$urandom, $urandom});
      hold_writes();
      send_mac(mac);
      send_mac(mac);
      hold_requests();

      // ---------------- random phases ----------------
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: begin
               node  = '0;
               basis = '0;
            end
            1: begin
               node  = '1;
               basis = '1;
            end
            3: begin
               node  = DEFAULT_NODE;
               basis = DEFAULT_BASIS;
            end
            default: begin
               node  = NODE_W'($urandom);
               basis = {$urandom, $urandom};
            end
         endcase
         // table contents survive the register change
         write_reg(CSR_NODE_NUMBER, {56'd0, node});
         write_reg(CSR_SALTED_BASIS, basis);
         write_reg(CSR_IDX_W'($urandom_range(255, CSR_SALTED_BASIS + 1)),
                   {$urandom, $urandom});
         hold_writes();

         set_pacing(phase % 4);
         pool_size = $urandom_range(POOL_MAX, 4);
         for (int i = 0; i < POOL_MAX; i++) mac_pool[i] = MAC_W'({$urandom, $urandom});

         repeat (ITEMS_PER_PHASE) send_mac(next_random_mac());
         hold_requests();
      end

      // ---------------- drain and verdict ----------------
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_seen == items_sent) begin
         $display("PASS station_identity_tracker_top");
      end else begin
         $display("FAIL station_identity_tracker_top");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/sit_pkg.sv
rtl/sit_channels.sv
rtl/sit_ram.sv
rtl/sit_mix_unit.sv
rtl/station_identity_tracker_top.sv
test/sit_tb_checker.sv
test/station_identity_tracker_top_tb.sv
